### design/particle_spawn_and_euler_update_assert.svh
// ----------------------------------------------------------------------------
// particle spawn and euler update: assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SPAWN_AND_EULER_UPDATE_ASSERT_SVH
`define PARTICLE_SPAWN_AND_EULER_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS
// check held while out of reset
`define PSEU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check held on every edge, reset included
`define PSEU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSEU_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSEU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/pseu_pkg.sv
// ----------------------------------------------------------------------------
// pseu_pkg
// types, constants and fixed-point helpers for the particle spawn/update block
// ----------------------------------------------------------------------------
package pseu_pkg;

    // default sizing
    localparam int NUM_SLOTS_DEF    = 32;
    localparam int SPAWN_PERIOD_DEF = 3277;
    localparam int MAX_RESULTS      = 32;

    // spawn box: half-width 0.1 in q8.8, full span 52
    localparam int BOX_HALF = 26;
    localparam int BOX_SPAN = 52;

    // field widths
    localparam int Q_W    = 16;
    localparam int LIFE_W = 26;
    localparam int LT_W   = 24;
    localparam int CD_W   = 18;
    localparam int SLOT_OUT_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // most negative life value
    localparam logic signed [LIFE_W-1:0] LIFE_MIN  = {1'b1, {(LIFE_W-1){1'b0}}};
    localparam logic signed [LIFE_W-1:0] LIFE_DEAD = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 3'd7;

    // register reset values
    localparam logic signed [Q_W-1:0] EMIT_RST   = 16'sd0;
    localparam logic signed [Q_W-1:0] DIR_X_RST  = 16'sd0;
    localparam logic signed [Q_W-1:0] DIR_Y_RST  = 16'sd256;
    localparam logic signed [Q_W-1:0] DIR_Z_RST  = 16'sd0;
    localparam logic [Q_W-1:0]        GRAV_RST   = 16'd0;
    localparam logic [LT_W-1:0]       LIFETIME_RST = 24'd65536;

    typedef logic signed [Q_W-1:0] t_q88;
    typedef t_q88 [2:0] t_vec3;

    // input request
    typedef struct packed {
        logic [15:0] delta_time;
        logic [15:0] rand_x;
        logic [15:0] rand_y;
        logic [15:0] rand_z;
    } t_in;

    // result request
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  alive;
        logic signed [15:0]    pos_x;
        logic signed [15:0]    pos_y;
        logic signed [15:0]    pos_z;
        logic [LT_W-1:0]       life_left;
        logic                  last_slot;
    } t_out;

    // one slot as held in the slot memory
    typedef struct packed {
        logic signed [LIFE_W-1:0] life;
        t_vec3                    vel;
        t_vec3                    pos;
    } t_rec;

    // saturate a 19-bit signed sum to q8.8
    function automatic t_q88 sat16(input logic signed [18:0] v);
        t_q88 r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // floor((p + 32768) / 65536) for a product well inside 33 bits
    function automatic logic signed [17:0] scale_round(input logic signed [33:0] p);
        logic signed [33:0] s;
        s = p + 34'sd32768;
        return s[33:16];
    endfunction

    // random spawn coordinate: centre - 26 + floor(rnd * 52 / 65536), saturated
    function automatic t_q88 spawn_pos(input t_q88 centre, input logic [15:0] rnd);
        logic [21:0] prod;
        logic [5:0]  idx;
        prod = 22'(rnd) * 22'(BOX_SPAN);
        idx  = prod[21:16];
        return sat16(19'(centre) + 19'($signed({1'b0, idx})) - 19'(BOX_HALF));
    endfunction

endpackage

### design/particle_spawn_and_euler_update.sv
// ----------------------------------------------------------------------------
// particle_spawn_and_euler_update
// spawn countdown, slot revival and explicit euler step over a slot memory,
// one result request per slot, for the first 32 slots at most, in slot order
// ----------------------------------------------------------------------------
// sequence: once a tick is accepted the gravity step is formed, then each slot
//   in turn is read, prepared, stepped axis by axis and written back; no new tick
//   is taken until the last slot is written back, and write-back waits while the result side holds off
// throughput: set by the one shared 17x17 multiplier (gravity once per tick,
//   three axis products per slot) and the single-port slot memory
// reset: synchronous; registers to defaults, countdown to the spawn period
module particle_spawn_and_euler_update #(
    parameter int NUM_SLOTS    = pseu_pkg::NUM_SLOTS_DEF,
    parameter int SPAWN_PERIOD = pseu_pkg::SPAWN_PERIOD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pseu_pkg::t_in                       i_in_data,
    // result requests
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pseu_pkg::t_out                      o_out_data,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [pseu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pseu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

`include "particle_spawn_and_euler_update_assert.svh"

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NRES   = (NUM_SLOTS < pseu_pkg::MAX_RESULTS) ?
                            NUM_SLOTS : pseu_pkg::MAX_RESULTS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W:0]   NRES_C    = (SLOT_W + 1)'(NRES);
    localparam logic [SLOT_W-1:0] LAST_RES  = SLOT_W'(NRES - 1);
    localparam logic signed [pseu_pkg::CD_W-1:0] CD_PERIOD =
        pseu_pkg::CD_W'(SPAWN_PERIOD);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GRAV = 3'd1;
    localparam logic [2:0] S_GST  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;

    // configuration registers
    pseu_pkg::t_q88              r_emit [3];
    pseu_pkg::t_q88              r_dir  [3];
    logic [15:0]                 r_grav;
    logic [pseu_pkg::LT_W-1:0]   r_lifetime;

    // control
    logic [2:0]                  r_state, n_state;
    logic [SLOT_W-1:0]           r_slot, n_slot;
    logic [1:0]                  r_axis, n_axis;
    logic                        r_armed, n_armed;
    logic signed [pseu_pkg::CD_W-1:0] r_cd, n_cd;
    logic                        r_out_valid, n_out_valid;
    logic [NUM_SLOTS-1:0]        r_vld;

    // tick payload
    logic [15:0]                 r_dt;
    logic [15:0]                 r_rnd [3];
    logic [15:0]                 r_gstep;

    // slot memory and working slot
    pseu_pkg::t_rec              r_mem [NUM_SLOTS];
    pseu_pkg::t_rec              r_rd_rec;
    logic                        r_rd_vld;
    logic signed [pseu_pkg::LIFE_W-1:0] r_life;
    pseu_pkg::t_q88              r_vel [3];
    pseu_pkg::t_q88              r_pos [3];

    // shared multiplier
    logic signed [16:0]          mul_a;
    logic signed [33:0]          mul_p;
    logic signed [33:0]          r_prod;
    logic signed [17:0]          rnd_step;

    pseu_pkg::t_out              r_out;

    logic                        in_fire;
    logic                        has_res;
    logic                        wb_go;
    logic signed [pseu_pkg::CD_W-1:0] cd_dec;
    pseu_pkg::t_rec              wb_rec;

    // prep-stage values
    logic signed [pseu_pkg::LIFE_W-1:0] rd_life;
    logic                        revive;
    logic signed [pseu_pkg::LIFE_W-1:0] life0;
    logic signed [pseu_pkg::LIFE_W:0]   life_dec;
    logic signed [pseu_pkg::LIFE_W-1:0] life1;
    pseu_pkg::t_q88              vel0 [3];
    pseu_pkg::t_q88              pos0 [3];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit[0]  <= pseu_pkg::EMIT_RST;
            r_emit[1]  <= pseu_pkg::EMIT_RST;
            r_emit[2]  <= pseu_pkg::EMIT_RST;
            r_dir[0]   <= pseu_pkg::DIR_X_RST;
            r_dir[1]   <= pseu_pkg::DIR_Y_RST;
            r_dir[2]   <= pseu_pkg::DIR_Z_RST;
            r_grav     <= pseu_pkg::GRAV_RST;
            r_lifetime <= pseu_pkg::LIFETIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pseu_pkg::CFG_EMIT_X:   r_emit[0]  <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_EMIT_Y:   r_emit[1]  <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_EMIT_Z:   r_emit[2]  <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_DIR_X:    r_dir[0]   <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_DIR_Y:    r_dir[1]   <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_DIR_Z:    r_dir[2]   <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_GRAVITY:  r_grav     <= i_cfg_wdata[15:0];
                pseu_pkg::CFG_LIFETIME: r_lifetime <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared multiplier: gravity once per tick, then one axis per cycle
    always_comb begin
        if (r_state == S_GRAV) begin
            mul_a = $signed({1'b0, r_grav});
        end else begin
            case (r_axis)
                2'd0:    mul_a = 17'(r_vel[0]);
                2'd1:    mul_a = 17'(r_vel[1]);
                2'd2:    mul_a = 17'(r_vel[2]);
                default: mul_a = '0;
            endcase
        end
    end

    assign mul_p    = mul_a * $signed({1'b0, r_dt});
    assign rnd_step = pseu_pkg::scale_round(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    // slot read, never-written slots read as dead and at rest
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_rec <= r_mem[r_slot];
            r_rd_vld <= r_vld[r_slot];
        end
    end

    // revive and life/gravity step
    always_comb begin
        rd_life = r_rd_vld ? r_rd_rec.life : pseu_pkg::LIFE_DEAD;
        revive  = rd_life[pseu_pkg::LIFE_W-1] && r_armed;
        for (int k = 0; k < 3; k++) begin
            vel0[k] = revive ? r_dir[k] : (r_rd_vld ? r_rd_rec.vel[k] : '0);
            pos0[k] = revive ? pseu_pkg::spawn_pos(r_emit[k], r_rnd[k])
                             : (r_rd_vld ? r_rd_rec.pos[k] : '0);
        end
        life0    = revive ? $signed({2'b00, r_lifetime}) : rd_life;
        life_dec = (pseu_pkg::LIFE_W + 1)'(life0) - $signed({11'd0, r_dt});
        // held at the negative limit
        if (life_dec[pseu_pkg::LIFE_W] && !life_dec[pseu_pkg::LIFE_W-1]) begin
            life1 = pseu_pkg::LIFE_MIN;
        end else begin
            life1 = life_dec[pseu_pkg::LIFE_W-1:0];
        end
    end

    // working slot and tick payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dt     <= i_in_data.delta_time;
            r_rnd[0] <= i_in_data.rand_x;
            r_rnd[1] <= i_in_data.rand_y;
            r_rnd[2] <= i_in_data.rand_z;
        end
        if (r_state == S_GST) begin
            r_gstep <= rnd_step[15:0];
        end
        if (r_state == S_PREP) begin
            r_life   <= life1;
            r_vel[0] <= vel0[0];
            r_vel[1] <= pseu_pkg::sat16(19'(vel0[1]) - $signed({3'b000, r_gstep}));
            r_vel[2] <= vel0[2];
            r_pos[0] <= pos0[0];
            r_pos[1] <= pos0[1];
            r_pos[2] <= pos0[2];
        end
        // position accumulates the previous axis product
        if (r_state == S_MUL && r_axis != 2'd0) begin
            r_pos[r_axis - 2'd1] <= pseu_pkg::sat16(19'(r_pos[r_axis - 2'd1])
                                                     + 19'(rnd_step));
        end
    end

    // write-back and result
    assign has_res = ({1'b0, r_slot} < NRES_C);
    assign wb_go   = (r_state == S_WB) && (!has_res || !r_out_valid || i_out_ready);

    always_comb begin
        wb_rec.life   = r_life;
        wb_rec.vel[0] = r_vel[0];
        wb_rec.vel[1] = r_vel[1];
        wb_rec.vel[2] = r_vel[2];
        wb_rec.pos[0] = r_pos[0];
        wb_rec.pos[1] = r_pos[1];
        wb_rec.pos[2] = r_pos[2];
    end

    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_mem[r_slot] <= wb_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wb_go) begin
            r_vld[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_go && has_res) begin
            r_out.slot      <= pseu_pkg::SLOT_OUT_W'(r_slot);
            r_out.alive     <= (r_life > 0);
            r_out.pos_x     <= r_pos[0];
            r_out.pos_y     <= r_pos[1];
            r_out.pos_z     <= r_pos[2];
            r_out.life_left <= (r_life > 0) ? r_life[pseu_pkg::LT_W-1:0] : '0;
            r_out.last_slot <= (r_slot == LAST_RES);
        end
    end

    // spawn countdown
    assign cd_dec = r_cd - $signed({2'b00, i_in_data.delta_time});

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_axis      = r_axis;
        n_armed     = r_armed;
        n_cd        = r_cd;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_GRAV;
                    n_slot  = '0;
                    if (cd_dec[pseu_pkg::CD_W-1]) begin
                        n_cd    = CD_PERIOD;
                        n_armed = 1'b1;
                    end else begin
                        n_cd    = cd_dec;
                        n_armed = 1'b0;
                    end
                end
            end
            S_GRAV: n_state = S_GST;
            S_GST:  n_state = S_READ;
            S_READ: n_state = S_PREP;
            S_PREP: begin
                n_state = S_MUL;
                n_axis  = 2'd0;
                if (revive) begin
                    n_armed = 1'b0;
                end
            end
            S_MUL: begin
                n_axis = r_axis + 2'd1;
                if (r_axis == 2'd3) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (wb_go) begin
                    if (has_res) begin
                        n_out_valid = 1'b1;
                    end
                    if (r_slot == LAST_SLOT) begin
                        n_state = S_IDLE;
                        n_armed = 1'b0;
                    end else begin
                        n_state = S_READ;
                        n_slot  = r_slot + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_axis      <= 2'd0;
            r_armed     <= 1'b0;
            r_cd        <= CD_PERIOD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_axis      <= n_axis;
            r_armed     <= n_armed;
            r_cd        <= n_cd;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `PSEU_ASSERT(a_arm_on_tick, i_clk, i_rst_n, $rose(r_armed) |-> $past(in_fire), "spawn armed outside a tick start")
    `PSEU_ASSERT(a_axis_idle, i_clk, i_rst_n, (r_state != S_MUL) |-> (r_axis == 2'd0), "axis count left running")
    `PSEU_ASSERT(a_last_mark, i_clk, i_rst_n, (o_out_valid && o_out_data.last_slot) |-> (o_out_data.slot == pseu_pkg::SLOT_OUT_W'(NRES - 1)), "last mark on wrong slot")
    `PSEU_ASSERT(a_cd_range, i_clk, i_rst_n, !r_cd[pseu_pkg::CD_W-1] && (r_cd <= CD_PERIOD), "spawn countdown out of range")
    `PSEU_ASSERT_ALWAYS(a_ready_idle, i_clk, (!i_rst_n) |=> (o_in_ready && !o_out_valid), "block busy after reset")

endmodule

### verif/particle_spawn_and_euler_update_checker.sv
// ----------------------------------------------------------------------------
// particle_spawn_and_euler_update_checker
// watches the tick, result and register ports of the particle block, keeps
// its own copy of the slot state, predicts the slot results (at most 32) of every
// accepted tick and compares each accepted result field by field
// ----------------------------------------------------------------------------
module particle_spawn_and_euler_update_checker #(
    parameter int NUM_SLOTS    = pseu_pkg::NUM_SLOTS_DEF,
    parameter int SPAWN_PERIOD = pseu_pkg::SPAWN_PERIOD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  pseu_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  pseu_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_we,
    input  logic [pseu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pseu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import pseu_pkg::*;

    localparam int SLOTS_HELD   = (NUM_SLOTS > 64) ? 64 : NUM_SLOTS;
    localparam int RESULT_COUNT = (SLOTS_HELD < MAX_RESULTS) ? SLOTS_HELD : MAX_RESULTS;
    localparam int LIFE_FLOOR   = -(1 << 25);

    // shadow registers
    t_q88            emit_reg [3];
    t_q88            dir_reg  [3];
    logic [15:0]     gravity_reg;
    logic [LT_W-1:0] lifetime_reg;

    // shadow slot state
    int   spawn_left;
    int   slot_life [SLOTS_HELD];
    t_q88 slot_vel  [SLOTS_HELD][3];
    t_q88 slot_pos  [SLOTS_HELD][3];

    // slot results still owed by the block, oldest first
    t_out slot_results_due [$];

    // saturate to q8.8
    function automatic t_q88 clip_q88(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return t_q88'(v);
    endfunction

    // floor((a * b + 32768) / 65536)
    function automatic longint round_scale(input longint a, input longint b);
        longint p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    task automatic clear_state();
        int i;
        emit_reg[0]  = EMIT_RST;
        emit_reg[1]  = EMIT_RST;
        emit_reg[2]  = EMIT_RST;
        dir_reg[0]   = DIR_X_RST;
        dir_reg[1]   = DIR_Y_RST;
        dir_reg[2]   = DIR_Z_RST;
        gravity_reg  = GRAV_RST;
        lifetime_reg = LIFETIME_RST;
        spawn_left   = SPAWN_PERIOD;
        for (i = 0; i < SLOTS_HELD; i++) begin
            slot_life[i]   = -1;
            slot_vel[i][0] = '0;
            slot_vel[i][1] = '0;
            slot_vel[i][2] = '0;
            slot_pos[i][0] = '0;
            slot_pos[i][1] = '0;
            slot_pos[i][2] = '0;
        end
        slot_results_due.delete();
    endtask

    task automatic write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_EMIT_X:   emit_reg[0]  = value[15:0];
            CFG_EMIT_Y:   emit_reg[1]  = value[15:0];
            CFG_EMIT_Z:   emit_reg[2]  = value[15:0];
            CFG_DIR_X:    dir_reg[0]   = value[15:0];
            CFG_DIR_Y:    dir_reg[1]   = value[15:0];
            CFG_DIR_Z:    dir_reg[2]   = value[15:0];
            CFG_GRAVITY:  gravity_reg  = value[15:0];
            CFG_LIFETIME: lifetime_reg = value[LT_W-1:0];
            default: ;
        endcase
    endtask

    // one tick: countdown, revive first dead slot, euler step every slot
    task automatic step_particles(input t_in req);
        int          dt;
        bit          armed;
        longint      gstep;
        longint      lv;
        longint      off;
        logic [15:0] rnd [3];
        t_out        res;
        int          i;
        int          k;
        dt     = int'(req.delta_time);
        rnd[0] = req.rand_x;
        rnd[1] = req.rand_y;
        rnd[2] = req.rand_z;
        armed  = 1'b0;

        spawn_left -= dt;
        if (spawn_left < 0) begin
            armed      = 1'b1;
            spawn_left = SPAWN_PERIOD;
        end
        gstep = round_scale(longint'(gravity_reg), longint'(dt));

        for (i = 0; i < SLOTS_HELD; i++) begin
            // revival needs a strictly negative life
            if (slot_life[i] < 0 && armed) begin
                for (k = 0; k < 3; k++) begin
                    off = -BOX_HALF + ((longint'(rnd[k]) * BOX_SPAN) >>> 16);
                    slot_pos[i][k] = clip_q88(longint'(emit_reg[k]) + off);
                    slot_vel[i][k] = dir_reg[k];
                end
                slot_life[i] = int'(lifetime_reg);
                armed = 1'b0;
            end

            // life runs down and sticks at its floor
            lv = longint'(slot_life[i]) - dt;
            if (lv < LIFE_FLOOR) begin
                lv = LIFE_FLOOR;
            end
            slot_life[i] = int'(lv);

            // gravity first, then position from the new velocity
            slot_vel[i][1] = clip_q88(longint'(slot_vel[i][1]) - gstep);
            for (k = 0; k < 3; k++) begin
                slot_pos[i][k] = clip_q88(longint'(slot_pos[i][k]) +
                                          round_scale(longint'(slot_vel[i][k]), dt));
            end

            if (i < RESULT_COUNT) begin
                res.slot      = i[SLOT_OUT_W-1:0];
                res.alive     = (slot_life[i] > 0);
                res.pos_x     = slot_pos[i][0];
                res.pos_y     = slot_pos[i][1];
                res.pos_z     = slot_pos[i][2];
                res.life_left = (slot_life[i] > 0) ? slot_life[i][LT_W-1:0] : '0;
                res.last_slot = (i == RESULT_COUNT - 1);
                slot_results_due.push_back(res);
            end
        end
    endtask

    task automatic flag_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
        $display("%0t checker: %s expected %0h got %0h", $time, field, want, got);
        o_fail_count++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (slot_results_due.size() == 0) begin
            $display("%0t checker: result expected none got slot %0d",
                     $time, got.slot);
            o_fail_count++;
        end else begin
            want = slot_results_due.pop_front();
            if (got.slot !== want.slot)           flag_field("slot", want.slot, got.slot);
            if (got.alive !== want.alive)         flag_field("alive", want.alive, got.alive);
            if (got.pos_x !== want.pos_x)         flag_field("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)         flag_field("pos_y", want.pos_y, got.pos_y);
            if (got.pos_z !== want.pos_z)         flag_field("pos_z", want.pos_z, got.pos_z);
            if (got.life_left !== want.life_left) begin
                flag_field("life_left", want.life_left, got.life_left);
            end
            if (got.last_slot !== want.last_slot) begin
                flag_field("last_slot", want.last_slot, got.last_slot);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_state();
    end

    // results are checked before the same edge's tick adds new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_cfg_we) begin
                write_shadow(i_cfg_index, i_cfg_wdata);
            end
            if (i_in_valid && i_in_ready) begin
                step_particles(i_in_data);
            end
        end
        o_pending = slot_results_due.size();
    end

endmodule

### verif/particle_spawn_and_euler_update_test.sv
// ----------------------------------------------------------------------------
// particle_spawn_and_euler_update_test
// drives ticks and register writes into the particle block: a directed part
// for saturation, zero life and reset state, a long drift run of full-length
// ticks, a fill run that leaves no dead slot, and random phases; a checker
// beside the block predicts and compares results
// ----------------------------------------------------------------------------
module particle_spawn_and_euler_update_test;
    import pseu_pkg::*;

    localparam int CYCLE_LIMIT  = 2500000;
    localparam int TAIL_CYCLES  = 300;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AT_TICK = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int ticks_sent;
    int burst_left;
    int cycles;

    particle_spawn_and_euler_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    particle_spawn_and_euler_update_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: own stall pattern, one long hold-off to back up the block
    initial begin
        int hold_left;
        int phase_left;
        bit ready_phase;
        bit held;
        hold_left   = 0;
        phase_left  = 0;
        ready_phase = 1'b0;
        held        = 1'b0;
        out_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (!held && ticks_sent >= HOLD_AT_TICK) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    ready_phase = !ready_phase;
                    if (!ready_phase) begin
                        phase_left = $urandom_range(1, 7);
                    end else if ($urandom_range(0, 3) == 0) begin
                        phase_left = $urandom_range(100, 400);
                    end else begin
                        phase_left = $urandom_range(1, 30);
                    end
                end
                phase_left--;
                out_ready <= ready_phase;
            end
        end
    end

    // random q8.8 value leaning on the extremes
    function automatic t_q88 pick_q88();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return t_q88'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_gravity();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(1, 2000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [LT_W-1:0] pick_lifetime();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return LT_W'($urandom_range(1, 20000));
            3:       return LT_W'($urandom_range(20000, 300000));
            default: return LT_W'($urandom_range(0, 24'hffffff));
        endcase
    endfunction

    function automatic t_in random_tick();
        t_in req;
        case ($urandom_range(0, 7))
            0:       req.delta_time = 16'd0;
            1:       req.delta_time = 16'hffff;
            2, 3:    req.delta_time = 16'($urandom_range(0, 3000));
            4, 5:    req.delta_time = 16'($urandom_range(3278, 12000));
            default: req.delta_time = 16'($urandom_range(0, 65535));
        endcase
        req.rand_x = 16'($urandom_range(0, 65535));
        req.rand_y = 16'($urandom_range(0, 65535));
        req.rand_z = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0) begin
            req.rand_x = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
            req.rand_z = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
        end
        return req;
    endfunction

    // offer one tick request; bursts end in a random gap
    task automatic send_tick(input t_in req);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        ticks_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(20, 300)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    task automatic tick(input logic [15:0] dt, input logic [15:0] rx,
                        input logic [15:0] ry, input logic [15:0] rz);
        t_in req;
        req.delta_time = dt;
        req.rand_x     = rx;
        req.rand_y     = ry;
        req.rand_z     = rz;
        send_tick(req);
    endtask

    // stop offering and let every owed result come back
    task automatic wait_idle();
        if (in_valid) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        while (pending != 0) @(negedge i_clk);
        burst_left = $urandom_range(1, 8);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // all eight registers; unused upper data bits get noise
    task automatic write_all(input t_q88 ex, input t_q88 ey, input t_q88 ez,
                             input t_q88 dx, input t_q88 dy, input t_q88 dz,
                             input logic [15:0] grav, input logic [LT_W-1:0] life);
        write_reg(CFG_EMIT_X,   {8'($urandom_range(0, 255)), ex});
        write_reg(CFG_EMIT_Y,   {8'($urandom_range(0, 255)), ey});
        write_reg(CFG_EMIT_Z,   {8'($urandom_range(0, 255)), ez});
        write_reg(CFG_DIR_X,    {8'($urandom_range(0, 255)), dx});
        write_reg(CFG_DIR_Y,    {8'($urandom_range(0, 255)), dy});
        write_reg(CFG_DIR_Z,    {8'($urandom_range(0, 255)), dz});
        write_reg(CFG_GRAVITY,  {8'($urandom_range(0, 255)), grav});
        write_reg(CFG_LIFETIME, life);
    endtask

    task automatic write_random_settings(input logic [LT_W-1:0] life);
        write_all(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88(),
                  pick_q88(), pick_gravity(), life);
    endtask

    // stimulus and verdict
    initial begin
        t_in req;
        int  n;
        int  p;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        ticks_sent = 0;
        burst_left = $urandom_range(1, 8);
        i_rst_n    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: quiet tick, then spawns at the box corners
        tick(16'd0, 16'h0000, 16'h0000, 16'h0000);
        tick(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        tick(16'd3278, 16'h0000, 16'h8000, 16'hffff);

        // saturation at the top and bottom of every range
        wait_idle();
        write_all(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sd256,
                  16'hffff, 24'hffffff);
        tick(16'hffff, 16'hffff, 16'h0000, 16'h8000);
        tick(16'hffff, 16'h0000, 16'hffff, 16'h0001);
        tick(16'd1, 16'd12345, 16'd54321, 16'h0000);

        wait_idle();
        write_all(16'sh8000, 16'sh7fff, 16'sd100, 16'sh8000, 16'sh7fff, 16'sh0000,
                  16'h0000, 24'd0);
        tick(16'hffff, 16'h0000, 16'h0000, 16'hffff);
        tick(16'hffff, 16'hffff, 16'hffff, 16'h0000);
        tick(16'd0, 16'h5555, 16'haaaa, 16'h5555);

        // life lands exactly on zero: not alive and not revived next tick
        wait_idle();
        write_all(16'sh0000, 16'sh0000, 16'sh0000, 16'sd10, -16'sd5, 16'sh0000,
                  16'd300, 24'd4000);
        tick(16'd4000, 16'h1234, 16'h4321, 16'h8000);
        tick(16'd4000, 16'h0000, 16'hffff, 16'h0000);
        tick(16'd4000, 16'hffff, 16'h0000, 16'hffff);
        tick(16'd0, 16'h0000, 16'h0000, 16'h0000);

        // long run of full-length ticks drives unrevived slots far negative
        wait_idle();
        write_random_settings(LT_W'($urandom_range(0, 60000)));
        for (n = 0; n < 100; n++) begin
            req            = random_tick();
            req.delta_time = 16'hffff - 16'($urandom_range(0, 300));
            send_tick(req);
        end

        // long lifetime and a spawn every tick: all slots alive, spawns dropped
        wait_idle();
        write_random_settings(LT_W'($urandom_range(8000000, 24'hffffff)));
        for (n = 0; n < 45; n++) begin
            req            = random_tick();
            req.delta_time = 16'($urandom_range(3278, 20000));
            send_tick(req);
        end

        // random phases under fresh settings
        for (p = 0; p < 6; p++) begin
            wait_idle();
            write_random_settings(pick_lifetime());
            for (n = 0; n < 10; n++) begin
                send_tick(random_tick());
            end
        end

        // drain, then watch for stray results
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
